>>> rtl/core/dirty_region_split_planner_top_macros.svh
// assertion macros for the dirty region split planner
`ifndef DIRTY_REGION_SPLIT_PLANNER_TOP_MACROS_SVH
`define DIRTY_REGION_SPLIT_PLANNER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/drsp_pkg.sv
// shared types, constants and helpers of the dirty region split planner
`default_nettype none
package drsp_pkg;

   localparam int DEF_MAX_COLUMNS = 4096;
   localparam int DEF_MAX_ROWS    = 2048;
   localparam int DEF_MAX_RECTS   = 1024;

   localparam int AREA_W  = 25;
   localparam int SUM_W   = 26;
   localparam int SCALE_W = 30;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_PIXELS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SINGLE_REGION = 2'd1;
   localparam logic [23:0] SCREEN_PIXELS_RESET = 24'd2073600;

   typedef struct packed {
      logic [11:0] span_begin;
      logic [12:0] span_end;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [11:0] rect_left;
      logic [12:0] rect_right;
      logic [10:0] rect_top;
      logic [11:0] rect_bottom;
      logic        region_valid;
      logic        last_region;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [11:0] l;
      logic [12:0] r;
      logic [10:0] t;
      logic [11:0] b;
   } rect_type;

   typedef struct packed {
      logic     push;
      logic     plan;
      rect_type rect;
   } cmd_type;

   typedef struct packed {
      logic [23:0] screen_pixels;
      logic        single_region_only;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_CHECK,
      ST_EMIT_FIRST,
      ST_EMIT_SECOND
   } back_state_type;

   function automatic rect_type rect_union(rect_type a, rect_type c);
      rect_type u;
      u.l = (a.l < c.l) ? a.l : c.l;
      u.r = (a.r > c.r) ? a.r : c.r;
      u.t = (a.t < c.t) ? a.t : c.t;
      u.b = (a.b > c.b) ? a.b : c.b;
      return u;
   endfunction

   function automatic logic [12:0] rect_width(rect_type a);
      return (a.r > {1'b0, a.l}) ? (a.r - {1'b0, a.l}) : 13'd0;
   endfunction

   function automatic logic [11:0] rect_height(rect_type a);
      return (a.b > {1'b0, a.t}) ? (a.b - {1'b0, a.t}) : 12'd0;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/drsp_chan_if.sv
// valid/ready channel carrying one payload beat
`default_nettype none
interface drsp_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/drsp_front.sv
// row tracker: builds rectangles from row spans and issues commands
`default_nettype none
module drsp_front #(
   parameter int MAX_COLUMNS = drsp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = drsp_pkg::DEF_MAX_ROWS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   drsp_chan_if.sink          req,
   output drsp_pkg::cmd_type  cmd,
   output logic               cmd_valid,
   input  wire logic          cmd_ready
);
   localparam int RC_W = $clog2(MAX_ROWS + 1);

   logic [RC_W-1:0]     row_ff, row_in;
   logic                in_rect_ff, in_rect_in;
   drsp_pkg::rect_type  open_ff, open_in;
   drsp_pkg::req_type   beat;
   logic [11:0]         b_cl;
   logic [12:0]         e_cl;
   logic                accept, active;

   assign beat      = req.data;
   assign req.ready = cmd_ready;
   assign accept    = req.valid && cmd_ready;

   always_comb begin
      b_cl = (32'(beat.span_begin) > MAX_COLUMNS) ? 12'(MAX_COLUMNS) : beat.span_begin;
      e_cl = (32'(beat.span_end) > MAX_COLUMNS) ? 13'(MAX_COLUMNS) : beat.span_end;
      active = ({1'b0, b_cl} < e_cl) && (row_ff < RC_W'(MAX_ROWS));
   end

   always_comb begin
      row_in     = row_ff;
      in_rect_in = in_rect_ff;
      open_in    = open_ff;
      cmd_valid  = 1'b0;
      cmd.push   = 1'b0;
      cmd.plan   = 1'b0;
      cmd.rect   = open_ff;
      if (accept) begin
         if (active) begin
            if (!in_rect_ff) begin
               open_in.l = b_cl;
               open_in.r = e_cl;
               open_in.t = 11'(row_ff);
               open_in.b = 12'(row_ff + RC_W'(1));
            end else begin
               if (b_cl < open_ff.l) open_in.l = b_cl;
               if (e_cl > open_ff.r) open_in.r = e_cl;
               open_in.b = 12'(row_ff + RC_W'(1));
            end
            in_rect_in = 1'b1;
         end else if (in_rect_ff) begin
            // an unchanged row closes the open rectangle
            cmd_valid  = 1'b1;
            cmd.push   = 1'b1;
            in_rect_in = 1'b0;
         end
         if (row_ff < RC_W'(MAX_ROWS)) row_in = row_ff + RC_W'(1);
         if (beat.last_row) begin
            cmd_valid = 1'b1;
            cmd.plan  = 1'b1;
            if (in_rect_in) begin
               cmd.push = 1'b1;
               cmd.rect = open_in;
            end
            row_in     = '0;
            in_rect_in = 1'b0;
            open_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         in_rect_ff <= 1'b0;
         open_ff    <= '0;
      end else begin
         row_ff     <= row_in;
         in_rect_ff <= in_rect_in;
         open_ff    <= open_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/drsp_queue.sv
// two-entry command queue between row tracker and planner
`default_nettype none
module drsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire drsp_pkg::cmd_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output drsp_pkg::cmd_type       out_data
);
   drsp_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic              push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) fill_ff <= fill_ff + 2'd1;
         else if (pop && !push) fill_ff <= fill_ff - 2'd1;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/drsp_back.sv
// planner: stores rectangles, scans splits and emits the regions
`default_nettype none
module drsp_back #(
   parameter int MAX_RECTS = drsp_pkg::DEF_MAX_RECTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire drsp_pkg::cmd_type  cmd,
   input  wire drsp_pkg::cfg_type  cfg,
   drsp_chan_if.source             rsp
);
   localparam int AW = $clog2(MAX_RECTS);
   localparam int CW = $clog2(MAX_RECTS + 1);

   drsp_pkg::back_state_type state_ff, state_in;

   drsp_pkg::rect_type rect_mem [MAX_RECTS];
   drsp_pkg::rect_type pre_mem  [MAX_RECTS];

   logic [CW-1:0]  count_ff;
   drsp_pkg::rect_type last_rect_ff, last_pre_ff;
   logic [AW-1:0]  rd_idx_ff;

   // scan pipeline
   logic                s1_v_ff, s2_v_ff, s3_v_ff;
   drsp_pkg::rect_type  pre_rd_ff, rect_rd_ff, suf_ff;
   drsp_pkg::rect_type  s2_pre_ff, s2_suf_ff, s3_pre_ff, s3_suf_ff;
   logic [12:0]         s2_pw_ff, s2_sw_ff;
   logic [11:0]         s2_ph_ff, s2_sh_ff;
   logic [drsp_pkg::AREA_W-1:0] s3_pa_ff, s3_sa_ff;
   logic [drsp_pkg::SUM_W-1:0]  best_ff, sum;
   drsp_pkg::rect_type  best_pre_ff, best_suf_ff;

   logic [drsp_pkg::AREA_W-1:0]  fa_ff;
   logic [drsp_pkg::SCALE_W-1:0] b12_ff, b10_ff, fa10;
   logic                split_ok;

   drsp_pkg::rect_type  out0_ff;
   logic                out0_valid_ff, two_ff;
   logic                rsp_valid_ff;
   drsp_pkg::rsp_type   rsp_data_ff;

   logic                out_free, issue, load_first, load_second, pop;
   logic                wr_en, full;
   logic [AW-1:0]       wr_addr;
   drsp_pkg::rect_type  wr_rect, wr_pre;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drsp_pkg::ST_IDLE:
            if (cmd_valid && cmd.plan) state_in = drsp_pkg::ST_PLAN;
         drsp_pkg::ST_PLAN:
            if (count_ff < CW'(2) || cfg.single_region_only) state_in = drsp_pkg::ST_EMIT_FIRST;
            else state_in = drsp_pkg::ST_SCAN;
         drsp_pkg::ST_SCAN:
            if (rd_idx_ff == '0) state_in = drsp_pkg::ST_DRAIN;
         drsp_pkg::ST_DRAIN:
            if (!s1_v_ff && !s2_v_ff && !s3_v_ff) state_in = drsp_pkg::ST_DECIDE;
         drsp_pkg::ST_DECIDE:
            state_in = drsp_pkg::ST_CHECK;
         drsp_pkg::ST_CHECK:
            state_in = drsp_pkg::ST_EMIT_FIRST;
         drsp_pkg::ST_EMIT_FIRST:
            if (out_free) state_in = two_ff ? drsp_pkg::ST_EMIT_SECOND : drsp_pkg::ST_IDLE;
         drsp_pkg::ST_EMIT_SECOND:
            if (out_free) state_in = drsp_pkg::ST_IDLE;
         default:
            state_in = drsp_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_ready   = 1'b0;
      issue       = 1'b0;
      load_first  = 1'b0;
      load_second = 1'b0;
      case (state_ff)
         drsp_pkg::ST_IDLE:        cmd_ready = 1'b1;
         drsp_pkg::ST_SCAN:        issue = 1'b1;
         drsp_pkg::ST_EMIT_FIRST:  load_first = out_free;
         drsp_pkg::ST_EMIT_SECOND: load_second = out_free;
         default:                  cmd_ready = 1'b0;
      endcase
   end

   assign pop = cmd_valid && cmd_ready;

   // rectangle store write
   always_comb begin
      full    = (count_ff == CW'(MAX_RECTS));
      wr_en   = pop && cmd.push;
      wr_addr = full ? AW'(MAX_RECTS - 1) : count_ff[AW-1:0];
      wr_rect = full ? drsp_pkg::rect_union(last_rect_ff, cmd.rect) : cmd.rect;
      wr_pre  = (count_ff == '0) ? cmd.rect : drsp_pkg::rect_union(last_pre_ff, cmd.rect);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_mem[wr_addr] <= wr_rect;
         pre_mem[wr_addr]  <= wr_pre;
      end
      if (issue) begin
         rect_rd_ff <= rect_mem[rd_idx_ff];
         pre_rd_ff  <= pre_mem[rd_idx_ff];
      end
   end

   always_comb begin
      sum  = {1'b0, s3_pa_ff} + {1'b0, s3_sa_ff};
      fa10 = drsp_pkg::SCALE_W'({fa_ff, 3'b000}) + drsp_pkg::SCALE_W'({fa_ff, 1'b0});
      split_ok = (b12_ff < fa10) &&
                 (b10_ff < drsp_pkg::SCALE_W'(cfg.screen_pixels));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drsp_pkg::ST_IDLE;
         count_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_ff      <= '1;
      end else begin
         state_ff <= state_in;
         s1_v_ff  <= issue;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         if (wr_en && !full) count_ff <= count_ff + CW'(1);
         if ((load_first && !two_ff) || load_second) count_ff <= '0;
         if (state_ff == drsp_pkg::ST_PLAN) best_ff <= '1;
         else if (s3_v_ff && (sum <= best_ff)) best_ff <= sum;
         if (load_first || load_second) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_rect_ff <= wr_rect;
         last_pre_ff  <= wr_pre;
      end
      if (state_ff == drsp_pkg::ST_PLAN) begin
         rd_idx_ff     <= AW'(count_ff - CW'(2));
         suf_ff        <= last_rect_ff;
         out0_ff       <= (count_ff == '0) ? '0 : last_pre_ff;
         out0_valid_ff <= (count_ff != '0);
         two_ff        <= 1'b0;
      end
      if (issue) rd_idx_ff <= rd_idx_ff - AW'(1);
      if (s1_v_ff) begin
         s2_pre_ff <= pre_rd_ff;
         s2_suf_ff <= suf_ff;
         s2_pw_ff  <= drsp_pkg::rect_width(pre_rd_ff);
         s2_ph_ff  <= drsp_pkg::rect_height(pre_rd_ff);
         s2_sw_ff  <= drsp_pkg::rect_width(suf_ff);
         s2_sh_ff  <= drsp_pkg::rect_height(suf_ff);
         suf_ff    <= drsp_pkg::rect_union(suf_ff, rect_rd_ff);
      end
      if (s2_v_ff) begin
         s3_pa_ff  <= s2_pw_ff * s2_ph_ff;
         s3_sa_ff  <= s2_sw_ff * s2_sh_ff;
         s3_pre_ff <= s2_pre_ff;
         s3_suf_ff <= s2_suf_ff;
      end
      if (s3_v_ff && (sum <= best_ff)) begin
         best_pre_ff <= s3_pre_ff;
         best_suf_ff <= s3_suf_ff;
      end
      if (state_ff == drsp_pkg::ST_DECIDE) begin
         fa_ff  <= drsp_pkg::rect_width(last_pre_ff) * drsp_pkg::rect_height(last_pre_ff);
         b12_ff <= drsp_pkg::SCALE_W'({best_ff, 3'b000}) + drsp_pkg::SCALE_W'({best_ff, 2'b00});
         b10_ff <= drsp_pkg::SCALE_W'({best_ff, 3'b000}) + drsp_pkg::SCALE_W'({best_ff, 1'b0});
      end
      if (state_ff == drsp_pkg::ST_CHECK) begin
         out0_ff       <= split_ok ? best_pre_ff : last_pre_ff;
         out0_valid_ff <= 1'b1;
         two_ff        <= split_ok;
      end
      if (load_first) begin
         rsp_data_ff.rect_left    <= out0_ff.l;
         rsp_data_ff.rect_right   <= out0_ff.r;
         rsp_data_ff.rect_top     <= out0_ff.t;
         rsp_data_ff.rect_bottom  <= out0_ff.b;
         rsp_data_ff.region_valid <= out0_valid_ff;
         rsp_data_ff.last_region  <= !two_ff;
      end else if (load_second) begin
         rsp_data_ff.rect_left    <= best_suf_ff.l;
         rsp_data_ff.rect_right   <= best_suf_ff.r;
         rsp_data_ff.rect_top     <= best_suf_ff.t;
         rsp_data_ff.rect_bottom  <= best_suf_ff.b;
         rsp_data_ff.region_valid <= 1'b1;
         rsp_data_ff.last_region  <= 1'b1;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/dirty_region_split_planner_top.sv
// top level of the dirty region split planner
// throughput: one row beat per cycle while the command queue has room
// a frame end with n stored rectangles keeps the planner on a split scan
//   that reads one stored rectangle per cycle
// with fewer than two rectangles or in merged mode, the first result
//   comes without a split scan
// reset: synchronous, clears frame state, restores register defaults
`default_nettype none
`include "dirty_region_split_planner_top_macros.svh"
module dirty_region_split_planner_top #(
   parameter int MAX_COLUMNS = drsp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = drsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_RECTS   = drsp_pkg::DEF_MAX_RECTS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   drsp_chan_if.sink    req_chan,
   drsp_chan_if.source  rsp_chan,
   drsp_chan_if.sink    csr_chan
);
   // configuration registers, written whenever the csr channel has a beat for their address
   drsp_pkg::cfg_type cfg_ff;
   drsp_pkg::csr_type csr_beat;

   assign csr_chan.ready = 1'b1;
   assign csr_beat       = csr_chan.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_pixels      <= drsp_pkg::SCREEN_PIXELS_RESET;
         cfg_ff.single_region_only <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_beat.addr)
            drsp_pkg::CSR_SCREEN_PIXELS: cfg_ff.screen_pixels <= csr_beat.wdata;
            drsp_pkg::CSR_SINGLE_REGION: cfg_ff.single_region_only <= csr_beat.wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // front to queue
   drsp_pkg::cmd_type front_cmd, back_cmd;
   logic              front_valid, front_ready;
   // queue to back
   logic              back_valid, back_ready;

   // row tracker: turns row spans into rectangle push and plan commands
   drsp_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   // short queue so rows keep flowing while the planner works, until it fills
   drsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_cmd)
   );

   // planner: rectangle store, split scan, region output register
   drsp_back #(
      .MAX_RECTS (MAX_RECTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .cfg       (cfg_ff),
      .rsp       (rsp_chan)
   );

   // checks on the result beats
   drsp_pkg::rsp_type rsp_beat;
   assign rsp_beat = rsp_chan.data;

   `DRSP_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_chan.valid && !rsp_beat.region_valid, rsp_beat.last_region, "empty frame beat must be the last")
   `DRSP_ASSERT_NOW(a_empty_is_zero, clock, reset, rsp_chan.valid && !rsp_beat.region_valid, rsp_beat.rect_left == 12'd0 && rsp_beat.rect_right == 13'd0 && rsp_beat.rect_bottom == 12'd0, "empty frame beat must carry zeros")
   `DRSP_ASSERT_NOW(a_region_nonempty, clock, reset, rsp_chan.valid && rsp_beat.region_valid, rsp_beat.rect_right > {1'b0, rsp_beat.rect_left} && rsp_beat.rect_bottom > {1'b0, rsp_beat.rect_top}, "emitted region has no area")
   `DRSP_ASSERT_NEXT(a_first_then_last, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_beat.last_region, !rsp_chan.valid || rsp_beat.last_region, "split frame must end with a last beat")

endmodule
`default_nettype wire

>>> dv/tb.sv
// testbench for the dirty region split planner: directed and random frames checked against a predictor
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS  = 4096;
   localparam int MAX_ROWS  = 2048;
   localparam int MAX_RECTS = 1024;
   localparam int LIMIT_CYCLES = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   drsp_chan_if #(.payload_type(drsp_pkg::req_type)) req_chan ();
   drsp_chan_if #(.payload_type(drsp_pkg::rsp_type)) rsp_chan ();
   drsp_chan_if #(.payload_type(drsp_pkg::csr_type)) csr_chan ();

   dirty_region_split_planner_top i_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   // predictor state: registers and the frame being collected
   logic [23:0]        pix_limit;
   logic               merge_only;
   int                 row_idx;
   bit                 span_open;
   drsp_pkg::rect_type open_span;
   drsp_pkg::rect_type rects[$];
   drsp_pkg::rect_type prefix[$];
   drsp_pkg::rsp_type  pending_regions[$];

   int  mismatches = 0;
   int  cycle_count = 0;
   int  stall_hold = 0;
   int  rx_gap = 0;
   bit  stalls_on = 1;
   event hold_go;

   function automatic drsp_pkg::rect_type merge_box(drsp_pkg::rect_type a,
                                                    drsp_pkg::rect_type c);
      drsp_pkg::rect_type u;
      u.l = (a.l < c.l) ? a.l : c.l;
      u.r = (a.r > c.r) ? a.r : c.r;
      u.t = (a.t < c.t) ? a.t : c.t;
      u.b = (a.b > c.b) ? a.b : c.b;
      return u;
   endfunction

   function automatic longint box_area(drsp_pkg::rect_type a);
      longint w, h;
      w = (a.r > a.l) ? longint'(a.r) - longint'(a.l) : 0;
      h = (a.b > a.t) ? longint'(a.b) - longint'(a.t) : 0;
      return w * h;
   endfunction

   function automatic void store_rect(drsp_pkg::rect_type a);
      int n;
      n = rects.size();
      if (n < MAX_RECTS) begin
         rects.push_back(a);
         prefix.push_back(n ? merge_box(prefix[n-1], a) : a);
      end else begin
         rects[n-1]  = merge_box(rects[n-1], a);
         prefix[n-1] = merge_box(prefix[n-1], a);
      end
   endfunction

   function automatic drsp_pkg::rsp_type region(drsp_pkg::rect_type a, bit vld, bit lst);
      drsp_pkg::rsp_type r;
      r.rect_left = a.l; r.rect_right = a.r; r.rect_top = a.t; r.rect_bottom = a.b;
      r.region_valid = vld; r.last_region = lst;
      return r;
   endfunction

   // tracks one row beat and predicts the regions when it ends the frame
   function automatic void plan_row(drsp_pkg::req_type it);
      int b, e, n, split, i;
      longint best, s;
      drsp_pkg::rect_type suf, z;
      b = it.span_begin; e = it.span_end;
      if (b > MAX_COLS) b = MAX_COLS;
      if (e > MAX_COLS) e = MAX_COLS;
      if (b < e && row_idx < MAX_ROWS) begin
         if (!span_open) begin
            open_span.l = 12'(b); open_span.r = 13'(e);
            open_span.t = 11'(row_idx); open_span.b = 12'(row_idx + 1);
            span_open = 1;
         end else begin
            if (b < open_span.l) open_span.l = 12'(b);
            if (e > open_span.r) open_span.r = 13'(e);
            open_span.b = 12'(row_idx + 1);
         end
      end else if (span_open) begin
         store_rect(open_span);
         span_open = 0;
      end
      if (row_idx < MAX_ROWS) row_idx++;
      if (!it.last_row) return;
      if (span_open) begin
         store_rect(open_span);
         span_open = 0;
      end
      n = rects.size();
      z = '0;
      if (n == 0) pending_regions.push_back(region(z, 0, 1));
      else if (n == 1 || merge_only) pending_regions.push_back(region(prefix[n-1], 1, 1));
      else begin
         suf = rects[n-1];
         best = 64'h7fff_ffff_ffff_ffff;
         split = 0;
         for (i = n - 2; i >= 0; i--) begin
            s = box_area(prefix[i]) + box_area(suf);
            if (s <= best) begin best = s; split = i; end
            suf = merge_box(suf, rects[i]);
         end
         if ((best * 12) / 10 < box_area(prefix[n-1]) && best * 10 < longint'(pix_limit)) begin
            suf = rects[n-1];
            for (i = n - 1; i > split + 1; i--) suf = merge_box(suf, rects[i-1]);
            pending_regions.push_back(region(prefix[split], 1, 0));
            pending_regions.push_back(region(suf, 1, 1));
         end else pending_regions.push_back(region(prefix[n-1], 1, 1));
      end
      row_idx = 0; span_open = 0; open_span = '0;
      rects.delete(); prefix.delete();
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(hold_go);
      stall_hold = 400;
      while (stall_hold > 0) begin
         @(posedge clock);
         stall_hold--;
      end
   end

   // receiver: random stalls, a few long ones, plus the forced hold-off
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (stall_hold > 0) rsp_chan.ready <= 1'b0;
      else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!stalls_on) rsp_chan.ready <= 1'b1;
      else if ($urandom_range(0, 99) == 0) begin
         rx_gap <= $urandom_range(10, 60);
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= ($urandom_range(0, 99) < 70);
   end

   // result checker
   always @(posedge clock) begin
      drsp_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_regions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected region beat %p", rsp_chan.data);
         end else begin
            want = pending_regions.pop_front();
            if (rsp_chan.data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("region mismatch: expected %p got %p", want, rsp_chan.data);
            end
         end
      end
   end

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (g) @(posedge clock);
   endtask

   // sends one row beat, predicting at acceptance; valid stays up for the next beat
   task automatic send_row(int b, int e, bit lst, bit gaps = 1);
      drsp_pkg::req_type it;
      if (gaps && $urandom_range(0, 2) == 0) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         idle_gap();
      end
      it.span_begin = 12'(b); it.span_end = 13'(e); it.last_row = lst;
      req_chan.data  <= it;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      plan_row(it);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_regions.size() != 0) @(posedge clock);
      repeat (MAX_RECTS + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic [drsp_pkg::CSR_ADDR_W-1:0] idx, int val);
      drsp_pkg::csr_type c;
      c.addr = idx; c.wdata = 24'(val);
      csr_chan.data  <= c;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == drsp_pkg::CSR_SCREEN_PIXELS) pix_limit = c.wdata;
      else merge_only = c.wdata[0];
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // random frame of blocks of changed rows separated by unchanged ones
   task automatic random_frame(int rows);
      int r, b, w;
      for (r = 0; r < rows; r++) begin
         if ($urandom_range(0, 3) == 0) begin
            b = $urandom_range(0, 4095); send_row(b, $urandom_range(0, b), 0);
         end else begin
            b = $urandom_range(0, 3000); w = $urandom_range(1, 1100);
            if ($urandom_range(0, 15) == 0) send_row($urandom_range(0, 4095), $urandom_range(0, 8191), 0);
            else send_row(b, b + w, 0);
         end
      end
      b = $urandom_range(0, 4000);
      send_row(b, $urandom_range(0, 1) ? b + $urandom_range(1, 90) : b, 1);
   endtask

   task automatic test_directed();
      send_row(0, 0, 1);                    // nothing changed
      send_row(4095, 4096, 1);              // single column at the far edge
      send_row(0, 8191, 0);                 // wide span clamped
      send_row(4095, 8191, 1);
      send_row(10, 20, 0); send_row(10, 20, 0); send_row(0, 0, 0);
      send_row(0, 0, 0); send_row(0, 0, 0); send_row(3000, 3010, 1); // worthwhile split
      send_row(0, 4096, 0); send_row(5, 5, 0); send_row(0, 4096, 1); // two full-width rows, split still worthwhile
      send_row(100, 50, 0); send_row(2048, 1024, 1);                // empty rows only
   endtask

   task automatic test_modes();
      wait_drained();
      write_reg(drsp_pkg::CSR_SINGLE_REGION, 1);
      send_row(10, 20, 0); send_row(0, 0, 0); send_row(3000, 3010, 1);
      wait_drained();
      write_reg(drsp_pkg::CSR_SINGLE_REGION, 0);
      write_reg(drsp_pkg::CSR_SCREEN_PIXELS, 0);      // split never wins
      send_row(10, 20, 0); send_row(0, 0, 0); send_row(3000, 3010, 1);
      wait_drained();
      write_reg(drsp_pkg::CSR_SCREEN_PIXELS, 24'hffffff);
   endtask

   task automatic test_many_rows();
      int r;
      // one long frame of alternating rows, a long split scan
      for (r = 0; r < 200; r++)
         send_row((r & 1) ? 0 : (r * 13 % 4000), (r & 1) ? 0 : (r * 13 % 4000) + 7, 0, 0);
      send_row(1, 2, 1, 0);
   endtask

   task automatic test_random(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         int rows;
         rows = $urandom_range(1, 14);
         random_frame(rows);
         sent += rows + 1;
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
            if ($urandom_range(0, 1))
               write_reg(drsp_pkg::CSR_SCREEN_PIXELS, $urandom_range(0, 24'hffffff));
            else write_reg(drsp_pkg::CSR_SINGLE_REGION, $urandom_range(0, 1));
         end
      end
   endtask

   task automatic test_backpressure();
      int k;
      -> hold_go;
      for (k = 0; k < 60; k++) send_row(5, 9, k % 2, 0);
      req_chan.valid <= 1'b0;
      while (pending_regions.size() != 0) @(posedge clock);
      @(posedge clock);
      stalls_on = 0;
      for (k = 0; k < 30; k++) send_row(k * 3, k * 3 + 4, (k % 5) == 4, 0);
      stalls_on = 1;
   endtask

   initial begin
      req_chan.valid = 1'b0; req_chan.data = '0;
      csr_chan.valid = 1'b0; csr_chan.data = '0;
      pix_limit = drsp_pkg::SCREEN_PIXELS_RESET; merge_only = 1'b0;
      row_idx = 0; span_open = 0; open_span = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_modes();
      test_random(170);
      test_backpressure();
      wait_drained();
      test_many_rows();
      wait_drained();
      write_reg(drsp_pkg::CSR_SCREEN_PIXELS, drsp_pkg::SCREEN_PIXELS_RESET);
      test_random(170);
      wait_drained();
      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
